### rtl/core/motor_feedback_multiturn_angle_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the motor feedback multi-turn angle block
// Implication checks in the same cycle and in the next cycle.
// ----------------------------------------------------------------------------
`ifndef MOTOR_FEEDBACK_MULTITURN_ANGLE_ASSERT_SVH
`define MOTOR_FEEDBACK_MULTITURN_ANGLE_ASSERT_SVH

`ifndef SYNTHESIS
`define MFMA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mfma same-cycle check failed");
`define MFMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mfma next-cycle check failed");
`else
`define MFMA_ASSERT_SAME(label, clk, rst, ante, cons)
`define MFMA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/mfma_pkg.sv
// ----------------------------------------------------------------------------
// mfma_pkg
// Types and constants shared by the motor feedback multi-turn angle block.
// ----------------------------------------------------------------------------
package mfma_pkg;

   localparam int SLOT_COUNT    = 10;
   localparam int SLOT_W        = 4;
   localparam int ENCODER_RANGE = 8192;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 32;
   localparam int TYPES_W       = 2 * SLOT_COUNT;

   localparam logic [3:0]  FRAME_LENGTH = 4'd8;
   localparam logic [10:0] ID_FIRST     = 11'h201;
   localparam logic [10:0] ID_SECOND    = 11'h202;
   localparam logic [10:0] ID_FOURTH    = 11'h204;
   localparam logic [10:0] ID_FIFTH     = 11'h205;
   localparam logic [10:0] ID_EIGHTH    = 11'h208;
   localparam logic [SLOT_W-1:0] SLOT_GIMBAL_BASE  = 4'd8;
   localparam logic [SLOT_W-1:0] SLOT_CHASSIS_HIGH = 4'd4;

   localparam logic [TYPES_W-1:0]    TYPES_RESET        = '0;
   localparam logic [CSR_DATA_W-1:0] SCALE_DIRECT_RESET = 32'd188743680;
   localparam logic [CSR_DATA_W-1:0] SCALE_LARGE_RESET  = 32'd9828757;
   localparam logic [CSR_DATA_W-1:0] SCALE_SMALL_RESET  = 32'd5242880;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SLOT_TYPES   = 2'd0,
      CSR_SCALE_DIRECT = 2'd1,
      CSR_SCALE_LARGE  = 2'd2,
      CSR_SCALE_SMALL  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MOTOR_NONE         = 2'd0,
      MOTOR_DIRECT       = 2'd1,
      MOTOR_GEARED_LARGE = 2'd2,
      MOTOR_GEARED_SMALL = 2'd3
   } motor_kind_type;

   typedef struct packed {
      logic        bus_select;
      logic [10:0] frame_id;
      logic [3:0]  length_code;
      logic [63:0] frame_bytes;
   } req_data_type;

   typedef struct packed {
      logic               accepted;
      logic [3:0]         slot_index;
      logic signed [15:0] encoder_value;
      logic signed [15:0] velocity_value;
      logic signed [15:0] current_value;
      logic [7:0]         temperature_value;
      logic signed [63:0] total_angle;
   } rsp_data_type;

   typedef struct packed {
      logic [TYPES_W-1:0]    slot_motor_types;
      logic [CSR_DATA_W-1:0] scale_direct;
      logic [CSR_DATA_W-1:0] scale_geared_large;
      logic [CSR_DATA_W-1:0] scale_geared_small;
   } cfg_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } route_type;

endpackage

### rtl/core/mfma_csr.sv
// ----------------------------------------------------------------------------
// mfma_csr
// Configuration registers: motor type map and the three scale factors.
// ----------------------------------------------------------------------------
module mfma_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mfma_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mfma_pkg::CSR_DATA_W-1:0]     csr_data,
   output mfma_pkg::cfg_type                   cfg
);

   mfma_pkg::cfg_type cfg_ff;
   mfma_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (mfma_pkg::csr_index_type'(csr_index))
            mfma_pkg::CSR_SLOT_TYPES:
               cfg_in.slot_motor_types = csr_data[mfma_pkg::TYPES_W-1:0];
            mfma_pkg::CSR_SCALE_DIRECT: cfg_in.scale_direct       = csr_data;
            mfma_pkg::CSR_SCALE_LARGE:  cfg_in.scale_geared_large = csr_data;
            mfma_pkg::CSR_SCALE_SMALL:  cfg_in.scale_geared_small = csr_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slot_motor_types   <= mfma_pkg::TYPES_RESET;
         cfg_ff.scale_direct       <= mfma_pkg::SCALE_DIRECT_RESET;
         cfg_ff.scale_geared_large <= mfma_pkg::SCALE_LARGE_RESET;
         cfg_ff.scale_geared_small <= mfma_pkg::SCALE_SMALL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/mfma_route.sv
// ----------------------------------------------------------------------------
// mfma_route
// Maps bus, identifier and length code of a frame to a motor slot.
// ----------------------------------------------------------------------------
module mfma_route (
   input  logic                bus_select,
   input  logic [10:0]         frame_id,
   input  logic [3:0]          length_code,
   output mfma_pkg::route_type route
);

   logic [10:0] offset_gimbal;
   logic [10:0] offset_chassis_high;
   logic [10:0] offset_chassis_low;

   assign offset_gimbal       = frame_id - mfma_pkg::ID_FIRST;
   assign offset_chassis_high = frame_id - mfma_pkg::ID_FIFTH;
   assign offset_chassis_low  = frame_id - mfma_pkg::ID_FIRST;

   always_comb begin
      route.hit  = 1'b0;
      route.slot = '0;
      if (length_code == mfma_pkg::FRAME_LENGTH) begin
         if (!bus_select) begin
            if (frame_id inside {[mfma_pkg::ID_FIRST:mfma_pkg::ID_SECOND]}) begin
               route.hit  = 1'b1;
               route.slot = mfma_pkg::SLOT_GIMBAL_BASE
                          + offset_gimbal[mfma_pkg::SLOT_W-1:0];
            end else if (frame_id inside {[mfma_pkg::ID_FIFTH:mfma_pkg::ID_EIGHTH]}) begin
               route.hit  = 1'b1;
               route.slot = mfma_pkg::SLOT_CHASSIS_HIGH
                          + offset_chassis_high[mfma_pkg::SLOT_W-1:0];
            end
         end else begin
            if (frame_id inside {[mfma_pkg::ID_FIRST:mfma_pkg::ID_FOURTH]}) begin
               route.hit  = 1'b1;
               route.slot = offset_chassis_low[mfma_pkg::SLOT_W-1:0];
            end
         end
      end
   end

endmodule

### rtl/core/mfma_angle.sv
// ----------------------------------------------------------------------------
// mfma_angle
// Per-slot encoder history and saturating multi-turn angle accumulator.
// ----------------------------------------------------------------------------
module mfma_angle (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  mfma_pkg::route_type       route,
   input  logic signed [15:0]        encoder_value,
   input  mfma_pkg::cfg_type         cfg,
   output logic signed [63:0]        total_angle
);

   localparam logic signed [17:0] RANGE_S = 18'(mfma_pkg::ENCODER_RANGE);
   localparam logic signed [63:0] ANGLE_MAX = {1'b0, {63{1'b1}}};
   localparam logic signed [63:0] ANGLE_MIN = {1'b1, {63{1'b0}}};

   logic signed [15:0] count_ff [mfma_pkg::SLOT_COUNT];
   logic signed [63:0] angle_ff [mfma_pkg::SLOT_COUNT];
   logic [mfma_pkg::SLOT_COUNT-1:0] seen_ff;

   mfma_pkg::motor_kind_type type_map [mfma_pkg::SLOT_COUNT];
   logic [mfma_pkg::SLOT_W-1:0] slot;
   mfma_pkg::motor_kind_type    slot_kind;
   logic [31:0]                 scale;
   logic                        seen;
   logic signed [15:0]          last;
   logic signed [63:0]          angle_old;
   logic signed [17:0]          direct;
   logic signed [17:0]          wrapped;
   logic [17:0]                 abs_direct;
   logic [17:0]                 abs_wrapped;
   logic signed [17:0]          step;
   logic signed [50:0]          product;
   logic signed [64:0]          sum;
   logic signed [63:0]          angle_in;
   logic signed [15:0]          count_in;
   logic                        update;

   always_comb begin
      for (int s = 0; s < mfma_pkg::SLOT_COUNT; s++) begin
         type_map[s] = mfma_pkg::motor_kind_type'(cfg.slot_motor_types[2*s +: 2]);
      end
   end

   assign slot       = route.hit ? route.slot : '0;
   assign slot_kind  = type_map[slot];
   assign seen       = seen_ff[slot];
   assign last       = count_ff[slot];
   assign angle_old  = seen ? angle_ff[slot] : '0;

   always_comb begin
      case (slot_kind)
         mfma_pkg::MOTOR_DIRECT:       scale = cfg.scale_direct;
         mfma_pkg::MOTOR_GEARED_LARGE: scale = cfg.scale_geared_large;
         mfma_pkg::MOTOR_GEARED_SMALL: scale = cfg.scale_geared_small;
         default:                      scale = '0;
      endcase
   end

   always_comb begin
      direct = 18'(encoder_value) - 18'(last);
      if (encoder_value < last) begin
         wrapped = direct + RANGE_S;
      end else if (encoder_value > last) begin
         wrapped = direct - RANGE_S;
      end else begin
         wrapped = '0;
      end
      abs_direct  = direct[17]  ? 18'(-direct)  : 18'(direct);
      abs_wrapped = wrapped[17] ? 18'(-wrapped) : 18'(wrapped);
      step        = (abs_wrapped > abs_direct) ? direct : wrapped;
   end

   assign product = 51'(step) * 51'($signed({1'b0, scale}));
   assign sum     = 65'(angle_old) + 65'(product);

   always_comb begin
      if (!seen) begin
         angle_in = '0;
      end else if (sum[64] != sum[63]) begin
         angle_in = sum[64] ? ANGLE_MIN : ANGLE_MAX;
      end else begin
         angle_in = sum[63:0];
      end
   end

   assign count_in    = encoder_value;
   assign update      = advance && route.hit && (slot_kind != mfma_pkg::MOTOR_NONE);
   assign total_angle = (slot_kind != mfma_pkg::MOTOR_NONE) ? angle_in : angle_old;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else if (update) begin
         seen_ff[slot] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         count_ff[slot] <= count_in;
         angle_ff[slot] <= angle_in;
      end
   end

endmodule

### rtl/core/motor_feedback_multiturn_angle.sv
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_angle
// Routes motor feedback frames to slots, unpacks them and keeps the
// multi-turn angle of every slot.
//
//   Channel   Direction  Handshake          Payload
//   req_      in         valid / stall      req_data_type
//   rsp_      out        valid / stall      rsp_data_type
//   csr_      in         valid / ready      index, data
//
// One request is taken every cycle while req_stall is low. The accepting edge
// loads the input register, and the result register loads from it when empty
// or not stalled; the result then shows on rsp_. The slot history is updated
// when a request moves into the result register, so the next request always
// sees it. Reset clears both valid flags and the slot history flags and
// returns the configuration registers to their defaults. A stalled result
// stalls the input register, and req_stall rises only when both hold.
// ----------------------------------------------------------------------------
module motor_feedback_multiturn_angle (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  mfma_pkg::req_data_type              req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output mfma_pkg::rsp_data_type              rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mfma_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mfma_pkg::CSR_DATA_W-1:0]     csr_data
);

   mfma_pkg::cfg_type      cfg;
   mfma_pkg::route_type    route;
   mfma_pkg::req_data_type req_ff;
   mfma_pkg::rsp_data_type rsp_ff;
   mfma_pkg::rsp_data_type rsp_in;
   logic                   req_valid_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_open;
   logic                   advance;
   logic signed [63:0]     total_angle;

   assign rsp_open  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && rsp_open;
   assign req_stall = req_valid_ff && !rsp_open;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   mfma_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mfma_route u_route (
      .bus_select  (req_ff.bus_select),
      .frame_id    (req_ff.frame_id),
      .length_code (req_ff.length_code),
      .route       (route)
   );

   mfma_angle u_angle (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .route         (route),
      .encoder_value (req_ff.frame_bytes[63:48]),
      .cfg           (cfg),
      .total_angle   (total_angle)
   );

   always_comb begin
      rsp_in = '0;
      if (route.hit) begin
         rsp_in.accepted          = 1'b1;
         rsp_in.slot_index        = route.slot;
         rsp_in.encoder_value     = req_ff.frame_bytes[63:48];
         rsp_in.velocity_value    = req_ff.frame_bytes[47:32];
         rsp_in.current_value     = req_ff.frame_bytes[31:16];
         rsp_in.temperature_value = req_ff.frame_bytes[15:8];
         rsp_in.total_angle       = total_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            req_valid_ff <= req_valid;
         end
         if (rsp_open) begin
            rsp_valid_ff <= req_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

`include "motor_feedback_multiturn_angle_assert.svh"

   `MFMA_ASSERT_SAME(a_reject_zero, clock, reset, rsp_valid && !rsp_data.accepted, rsp_data.total_angle == 64'sd0 && rsp_data.slot_index == 4'd0)
   `MFMA_ASSERT_SAME(a_slot_range, clock, reset, rsp_valid && rsp_data.accepted, rsp_data.slot_index < 4'd10)
   `MFMA_ASSERT_NEXT(a_take_fills, clock, reset, req_valid && !req_stall, req_valid_ff)
   `MFMA_ASSERT_SAME(a_stall_cause, clock, reset, req_stall, req_valid_ff && rsp_valid_ff && rsp_stall)

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: motor feedback multi-turn angle testbench
// Sends feedback frames to the block and holds a bit-accurate predictor of
// routing, unpacking and the per-slot multi-turn angle. Every result is
// compared field by field against the predicted queue. The run covers
// directed routing and wrap cases, random traffic under four idle and stall
// mixes, and a run of large encoder steps on two slots.
// ----------------------------------------------------------------------------
module tb;
   import mfma_pkg::*;

   localparam int     CYCLE_LIMIT      = 2_500_000;
   localparam int     RANDOM_PER_PHASE = 240;
   localparam int     LARGE_STEP_PAIRS = 32;
   localparam int     DRAIN_CYCLES     = 8;
   localparam int     MAX_REPORTS      = 40;
   localparam longint ANGLE_MAX        = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint ANGLE_MIN        = 64'sh8000_0000_0000_0000;

   logic                   clock;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_data_type           req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_data_type           rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   cfg_type      angle_cfg;
   logic [15:0]  hist_count [SLOT_COUNT];
   bit           hist_seen  [SLOT_COUNT];
   longint       hist_angle [SLOT_COUNT];
   int           last_enc   [SLOT_COUNT];
   rsp_data_type expected_feedback [$];

   int send_idle_pct   = 0;
   int rsp_stall_pct   = 0;
   int cycle_count     = 0;
   int mismatches      = 0;
   int requests_sent   = 0;
   int results_checked = 0;

   motor_feedback_multiturn_angle dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: timeout after %0d cycles", cycle_count);
         $display("tb: FAIL");
         $finish;
      end
   end

   function automatic rsp_data_type predict_feedback(input req_data_type frame);
      rsp_data_type   res;
      int             slot;
      motor_kind_type kind;
      logic [31:0]    scale;
      longint         enc;
      longint         last;
      longint         direct;
      longint         wrapped;
      longint         step;
      longint         prod;
      logic [64:0]    sum;
      res  = '0;
      slot = -1;
      if (frame.bus_select == 1'b0) begin
         if (frame.frame_id == ID_FIRST || frame.frame_id == ID_SECOND)
            slot = int'(SLOT_GIMBAL_BASE) + int'(frame.frame_id) - int'(ID_FIRST);
         else if (frame.frame_id >= ID_FIFTH && frame.frame_id <= ID_EIGHTH)
            slot = int'(SLOT_CHASSIS_HIGH) + int'(frame.frame_id) - int'(ID_FIFTH);
      end else if (frame.frame_id >= ID_FIRST && frame.frame_id <= ID_FOURTH) begin
         slot = int'(frame.frame_id) - int'(ID_FIRST);
      end
      if (slot < 0 || frame.length_code != FRAME_LENGTH)
         return res;

      res.accepted          = 1'b1;
      res.slot_index        = slot[3:0];
      res.encoder_value     = frame.frame_bytes[63:48];
      res.velocity_value    = frame.frame_bytes[47:32];
      res.current_value     = frame.frame_bytes[31:16];
      res.temperature_value = frame.frame_bytes[15:8];

      kind = motor_kind_type'(angle_cfg.slot_motor_types[2*slot +: 2]);
      if (kind != MOTOR_NONE) begin
         case (kind)
            MOTOR_DIRECT:       scale = angle_cfg.scale_direct;
            MOTOR_GEARED_LARGE: scale = angle_cfg.scale_geared_large;
            default:            scale = angle_cfg.scale_geared_small;
         endcase
         enc = longint'($signed(frame.frame_bytes[63:48]));
         if (!hist_seen[slot]) begin
            hist_count[slot] = frame.frame_bytes[63:48];
            hist_angle[slot] = 0;
            hist_seen[slot]  = 1'b1;
         end
         last   = longint'($signed(hist_count[slot]));
         direct = enc - last;
         if (enc < last)
            wrapped = direct + ENCODER_RANGE;
         else if (enc > last)
            wrapped = direct - ENCODER_RANGE;
         else
            wrapped = 0;
         step = ((wrapped < 0 ? -wrapped : wrapped) > (direct < 0 ? -direct : direct)) ?
                direct : wrapped;
         prod = step * longint'({32'd0, scale});
         sum  = {hist_angle[slot][63], hist_angle[slot]} + {prod[63], prod};
         if (sum[64] != sum[63])
            hist_angle[slot] = sum[64] ? ANGLE_MIN : ANGLE_MAX;
         else
            hist_angle[slot] = sum[63:0];
         hist_count[slot] = frame.frame_bytes[63:48];
      end
      res.total_angle = hist_angle[slot];
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      if (mismatches < MAX_REPORTS)
         $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
   endtask

   always @(posedge clock) begin
      rsp_data_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_checked++;
         if (expected_feedback.size() == 0) begin
            report_mismatch("result with no request outstanding");
         end else begin
            want = expected_feedback.pop_front();
            check_field("accepted", rsp_data.accepted, want.accepted);
            check_field("slot_index", rsp_data.slot_index, want.slot_index);
            check_field("encoder_value", rsp_data.encoder_value, want.encoder_value);
            check_field("velocity_value", rsp_data.velocity_value, want.velocity_value);
            check_field("current_value", rsp_data.current_value, want.current_value);
            check_field("temperature_value", rsp_data.temperature_value,
                        want.temperature_value);
            check_field("total_angle", rsp_data.total_angle, want.total_angle);
         end
      end
   end

   task automatic send_frame(input req_data_type frame);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= frame;
      do @(posedge clock); while (req_stall);
      expected_feedback.push_back(predict_feedback(frame));
      requests_sent++;
   endtask

   task automatic settle_pipeline();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_feedback.size() != 0);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SLOT_TYPES:   angle_cfg.slot_motor_types   = value[TYPES_W-1:0];
         CSR_SCALE_DIRECT: angle_cfg.scale_direct       = value;
         CSR_SCALE_LARGE:  angle_cfg.scale_geared_large = value;
         default:          angle_cfg.scale_geared_small = value;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [TYPES_W-1:0] types, input logic [31:0] direct,
                            input logic [31:0] large_scale,
                            input logic [31:0] small_scale);
      settle_pipeline();
      write_register(CSR_SLOT_TYPES, 32'(types));
      write_register(CSR_SCALE_DIRECT, direct);
      write_register(CSR_SCALE_LARGE, large_scale);
      write_register(CSR_SCALE_SMALL, small_scale);
   endtask

   function automatic req_data_type make_frame(input logic bus, input logic [10:0] id,
                                               input logic [3:0] len,
                                               input logic [63:0] bytes);
      req_data_type f;
      f.bus_select  = bus;
      f.frame_id    = id;
      f.length_code = len;
      f.frame_bytes = bytes;
      return f;
   endfunction

   function automatic req_data_type feedback_frame(input int slot, input int enc);
      logic [10:0] id;
      if (slot < 4)
         id = ID_FIRST + 11'(slot);
      else if (slot < 8)
         id = ID_FIFTH + 11'(slot - 4);
      else
         id = ID_FIRST + 11'(slot - 8);
      last_enc[slot] = int'($signed(16'(enc)));
      return make_frame(slot < 4, id, FRAME_LENGTH, {16'(enc), $urandom, 16'($urandom)});
   endfunction

   function automatic req_data_type random_frame();
      req_data_type f;
      int           slot;
      int           enc;
      slot = $urandom_range(SLOT_COUNT - 1);
      enc  = last_enc[slot];
      if ($urandom_range(99) < 85) begin
         case ($urandom_range(7))
            0: enc = enc + int'($urandom_range(600)) - 300;
            1: enc = enc + ($urandom_range(1) ? 4096 : -4096);
            2: enc = enc + ($urandom_range(1) ? 4095 : -4095) + ($urandom_range(1) ? 2 : 0);
            3: enc = enc + ($urandom_range(1) ? ENCODER_RANGE : -ENCODER_RANGE);
            4: enc = last_enc[slot];
            default: enc = int'($urandom_range(65535));
         endcase
         f = feedback_frame(slot, enc);
      end else if ($urandom_range(1)) begin
         f = feedback_frame(slot, int'($urandom_range(65535)));
         f.length_code = 4'($urandom);
      end else begin
         f = make_frame(1'($urandom), 11'($urandom), 4'($urandom), {$urandom, $urandom});
      end
      return f;
   endfunction

   task automatic test_routing();
      logic [10:0] id;
      configure(TYPES_RESET, SCALE_DIRECT_RESET, SCALE_LARGE_RESET, SCALE_SMALL_RESET);
      send_frame(make_frame(1'b0, ID_FIRST, FRAME_LENGTH, '1));
      send_frame(make_frame(1'b0, ID_SECOND, FRAME_LENGTH, '0));
      for (id = ID_FIFTH; id <= ID_EIGHTH; id++)
         send_frame(make_frame(1'b0, id, FRAME_LENGTH, {$urandom, $urandom}));
      for (id = ID_FIRST; id <= ID_FOURTH; id++)
         send_frame(make_frame(1'b1, id, FRAME_LENGTH, {$urandom, $urandom}));
      send_frame(make_frame(1'b0, ID_SECOND + 11'd1, FRAME_LENGTH, {$urandom, $urandom}));
      send_frame(make_frame(1'b1, ID_FIFTH, FRAME_LENGTH, {$urandom, $urandom}));
      send_frame(make_frame(1'b0, 11'h7FF, FRAME_LENGTH, '1));
      send_frame(make_frame(1'b1, 11'h000, FRAME_LENGTH, '1));
      send_frame(make_frame(1'b1, ID_FIRST, 4'h0, '1));
      send_frame(make_frame(1'b0, ID_FIFTH, 4'hF, '1));
   endtask

   task automatic test_wrap_steps();
      int walk [7] = '{100, 100, 4196, 100, 8292, -32768, 32767};
      configure(20'hF5539, 32'hFFFF_FFFF, 32'd0, SCALE_SMALL_RESET);
      foreach (walk[i])
         send_frame(feedback_frame(0, walk[i]));
      send_frame(feedback_frame(3, 1234));
      send_frame(feedback_frame(9, -1));
      send_frame(feedback_frame(9, 4095));
   endtask

   task automatic test_random_phases();
      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = 0;
         rsp_stall_pct = 0;
         case (phase)
            0: configure(20'($urandom), $urandom, $urandom, $urandom);
            1: configure(20'hF_FFFF, 32'd0, 32'd0, $urandom);
            2: configure(20'($urandom), SCALE_DIRECT_RESET, $urandom, SCALE_SMALL_RESET);
            default: configure(20'($urandom), '1, '1, '1);
         endcase
         case (phase)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 81;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 81;
            end
            default: begin
               send_idle_pct = 7;
               rsp_stall_pct = 7;
            end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_frame(random_frame());
      end
      send_idle_pct = 0;
      rsp_stall_pct = 0;
   endtask

   // Slot 0 climbs and slot 1 falls. Tied steps of 4096 counts take the wrapped
   // direction, so small moves against the climb still add to it, and a jump across
   // most of the range adds more.
   task automatic test_large_steps();
      int p_up;
      int p_down;
      configure((20'($urandom) & 20'hF_FFF0) | 20'h0_0005, '1, SCALE_LARGE_RESET,
                SCALE_SMALL_RESET);
      p_up   = last_enc[0];
      p_down = last_enc[1];
      for (int n = 0; n < LARGE_STEP_PAIRS; n++) begin
         if (p_up - 4096 >= -32768)
            p_up = p_up - 4096;
         else
            p_up = 32767;
         if (p_down + 4096 <= 32767)
            p_down = p_down + 4096;
         else
            p_down = -32768;
         send_frame(feedback_frame(0, p_up));
         send_frame(feedback_frame(1, p_down));
      end
   endtask

   initial begin
      angle_cfg = '{TYPES_RESET, SCALE_DIRECT_RESET, SCALE_LARGE_RESET, SCALE_SMALL_RESET};
      foreach (hist_count[s]) begin
         hist_count[s] = '0;
         hist_seen[s]  = 1'b0;
         hist_angle[s] = 0;
         last_enc[s]   = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_routing();
      test_wrap_steps();
      test_random_phases();
      test_large_steps();

      settle_pipeline();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb: %0d feedback requests sent, %0d results checked, %0d mismatches",
               requests_sent, results_checked, mismatches);
      $display("tb: routing, length codes, wrap ties, four idle mixes, large encoder steps");
      if (mismatches == 0 && expected_feedback.size() == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
